/* rtl/fpst_pkg.sv */
// Package for the Fenwick prefix-sum table: widths, command codes, FSM states
// and the control bundle sent to the node store. No dependencies.
`default_nettype none

package fpst_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned IndexW      = 10;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned SizeDefault = 1024;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_QUERY = 4'b1000
  } state_e;

  // rd: read node this cycle; wr: write back last read node; zero: write zeros
  typedef struct packed {
    logic rd;
    logic wr;
    logic zero;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/fpst_store.sv */
// Node store: one synchronous memory of tree nodes with a registered read
// port and a write port that adds to the last read word. Uses fpst_pkg.
`default_nettype none

module fpst_store
  import fpst_pkg::*;
#(
  parameter int unsigned Depth = SizeDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire mem_ctl_t         ctl_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] addend_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;
  logic [DataW-1:0] wr_data;

  // read-modify-write: new node = old node + addend, or zero when clearing
  assign wr_data   = ctl_i.zero ? '0 : rd_data_q + addend_i;
  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/fenwick_prefix_sum_table_core.sv */
// Top level of the Fenwick prefix-sum table: command port, node walker FSM
// and result register. Depends on fpst_pkg and fpst_store.
`default_nettype none

// Binary indexed tree over Size signed 64-bit entries, sums wrapping mod 2^64.
// A request is taken when start_i is high and busy_o is low; it carries
// command_i (add, query, clear), index_i and value_i. An add walks upward
// from node index+1, a query walks downward; each visited node takes one
// read of the single node memory, which does one read per cycle, with the
// write-back of the previous node overlapped. A query's sum appears on
// prefix_sum_o for one cycle with valid_o high, in the same cycle that
// busy_o drops; the receiver cannot stall it, so it must take it then. A
// query index of Size or more reads the sum of all entries. A clear sweeps
// the memory, one node a cycle, with busy_o high. The same clearing pass
// runs after reset before the first request is taken. An add beyond the
// table and the unused command code are taken and do nothing, and busy_o
// stays low.
module fenwick_prefix_sum_table_core
  import fpst_pkg::*;
#(
  parameter int unsigned Size = SizeDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [CmdW-1:0]   command_i,
  input  wire logic [IndexW-1:0] index_i,
  input  wire logic [DataW-1:0]  value_i,
  output logic                   valid_o,
  output logic      [DataW-1:0]  prefix_sum_o
);

  localparam int unsigned AddrW = (Size > 1) ? $clog2(Size) : 1;
  // node numbers run up to 2*Size during an add walk
  localparam int unsigned WalkW = $clog2(2 * Size + 1);
  localparam int unsigned NodeW = (WalkW > IndexW + 1) ? WalkW : IndexW + 1;

  localparam logic [NodeW-1:0] SizeNode = NodeW'(Size);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Size - 1);

  state_e           state_q, state_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             pend_q, pend_d;       // rd_data holds a freshly read node (at pend_addr in an add walk)
  logic [AddrW-1:0] pend_addr_q, pend_addr_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic             valid_q, valid_d;
  logic [DataW-1:0] sum_q, sum_d;

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic [DataW-1:0] rd_data;

  logic             accept;
  cmd_e             cmd;
  logic [NodeW-1:0] idx_ext;
  logic [NodeW-1:0] first_node;
  logic [NodeW-1:0] low_bit;
  logic [NodeW-1:0] node_m1;
  logic             add_in_range;
  logic             query_in_range;
  logic [DataW-1:0] acc_next;

  assign accept  = start_i && !busy_o;
  assign cmd     = cmd_e'(command_i);
  assign idx_ext = NodeW'(index_i);

  // entry e lives at node e+1; queries past the end saturate to the last node
  assign first_node = (idx_ext >= SizeNode) ? SizeNode : idx_ext + NodeW'(1);

  assign low_bit        = node_q & (~node_q + NodeW'(1));
  assign node_m1        = node_q - NodeW'(1);
  assign add_in_range   = (node_q <= SizeNode);
  assign query_in_range = (node_q != '0);
  assign acc_next       = pend_q ? acc_q + rd_data : acc_q;

  assign rd_addr = node_m1[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    clr_d       = clr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    val_d       = val_q;
    acc_d       = acc_q;
    valid_d     = 1'b0;
    sum_d       = sum_q;
    mem_ctl     = '0;
    wr_addr     = pend_addr_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          node_d = first_node;
          val_d  = value_i;
          acc_d  = '0;
          case (cmd)
            CMD_ADD: begin
              if (idx_ext < SizeNode) begin
                state_d = ST_ADD;
              end
            end
            CMD_QUERY: begin
              state_d = ST_QUERY;
            end
            CMD_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_CLEAR: begin
        mem_ctl.wr   = 1'b1;
        mem_ctl.zero = 1'b1;
        wr_addr      = clr_q;
        clr_d        = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end

      ST_ADD: begin
        // write back the node read last cycle; nodes rise strictly, so the
        // read issued now never hits the entry being written
        mem_ctl.wr = pend_q;
        if (add_in_range) begin
          mem_ctl.rd  = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = rd_addr;
          node_d      = node_q + low_bit;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_QUERY: begin
        acc_d = acc_next;
        if (query_in_range) begin
          mem_ctl.rd = 1'b1;
          pend_d     = 1'b1;
          node_d     = node_q - low_bit;
        end else begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          sum_d   = acc_next;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;   // clearing pass after reset
      clr_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    pend_addr_q <= pend_addr_d;
    val_q       <= val_d;
    acc_q       <= acc_d;
    sum_q       <= sum_d;
  end

  fpst_store #(
    .Depth (Size),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .addend_i  (val_q),
    .rd_data_o (rd_data)
  );

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign prefix_sum_o = sum_q;

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.rd && mem_ctl.wr) |-> (rd_addr != wr_addr))
    else $error("node read and write-back hit the same entry");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QUERY) |-> !mem_ctl.wr)
    else $error("memory written during a query walk");

  a_result_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($past(state_q) == ST_QUERY) && (state_q == ST_IDLE))
    else $error("result strobe without a finished query");

  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_CLEAR)) |=> (state_q == ST_CLEAR) && (clr_q == '0))
    else $error("clear request did not start the sweep");

  a_write_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.wr && !mem_ctl.zero) |-> $past(mem_ctl.rd))
    else $error("write-back without a preceding node read");
`endif

endmodule

`default_nettype wire
